// File: rtl/bog_pkg.sv
// Package with shared constants, register codes and an arithmetic helper for the offset gradient block.
package bog_pkg;

   localparam int COORD_LIMIT_DEF = 4096;
   localparam int TAP_LIMIT_DEF = 16;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_PAD_TOP       = 3'd0,
      REG_PAD_COLS      = 3'd1,
      REG_STRIDE_ROWS   = 3'd2,
      REG_STRIDE_COLS   = 3'd3,
      REG_DILATION_ROWS = 3'd4,
      REG_DILATION_COLS = 3'd5,
      REG_IMAGE_HEIGHT  = 3'd6,
      REG_IMAGE_WIDTH   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  pad_top;
      logic [7:0]  pad_cols;
      logic [3:0]  stride_rows;
      logic [3:0]  stride_cols;
      logic [3:0]  dilation_rows;
      logic [3:0]  dilation_cols;
      logic [12:0] image_height;
      logic [12:0] image_width;
   } cfg_type;

   typedef struct packed {
      logic [11:0] out_row;
      logic [11:0] out_col;
      logic [3:0]  tap_row;
      logic [3:0]  tap_col;
      logic [15:0] shift_row;
      logic [15:0] shift_col;
      logic [15:0] modulation;
      logic [15:0] upstream_grad;
      logic [15:0] value_top_left;
      logic [15:0] value_bottom_left;
      logic [15:0] value_top_right;
      logic [15:0] value_bottom_right;
   } req_word_type;

   typedef struct packed {
      logic [16:0] corner_row;
      logic [16:0] corner_col;
      logic [3:0]  valid_corners;
      logic [31:0] grad_top_left;
      logic [31:0] grad_bottom_left;
      logic [31:0] grad_top_right;
      logic [31:0] grad_bottom_right;
      logic [31:0] grad_shift_row;
      logic [31:0] grad_shift_col;
      logic [31:0] grad_modulation;
   } rsp_word_type;

   // Round half up at bit position s, then saturate to 32 bits.
   function automatic logic [31:0] round_sat(input logic signed [63:0] x, input int s);
      logic signed [63:0] r;
      begin
         r = (x + (64'sd1 <<< (s - 1))) >>> s;
         if (r > 64'sd2147483647) round_sat = 32'h7FFF_FFFF;
         else if (r < -64'sd2147483648) round_sat = 32'h8000_0000;
         else round_sat = r[31:0];
      end
   endfunction

endpackage

// File: rtl/bog_if.sv
// Valid/ready channel interface carrying one word of a parameterized payload type.
interface bog_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bilinear_offset_gradient.sv
// Top level: five-stage pipeline computing deformable convolution offset gradients.
//
//  channel | dir | handshake      | word
//  req     | in  | valid/ready    | sampling point: position, tap, shifts, samples
//  rsp     | out | valid/ready    | corner, valid mask, seven Q8.24 gradients
//  csr     | in  | APB psel/penable | eight configuration registers
//
// One word enters per cycle unless a stall holds the pipeline; rsp valid rises once the word reaches stage 5.
// The stages hold: base and floor coordinates; bounds and weights; first products;
// second products; rounding and saturation into the output register.
// A stall freezes each full stage whose successor cannot move; empty stages still fill.
// Reset is synchronous, clears the valid bits and returns the configuration to its defaults.
module bilinear_offset_gradient #(
   parameter int COORD_LIMIT = bog_pkg::COORD_LIMIT_DEF,
   parameter int TAP_LIMIT = bog_pkg::TAP_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bog_if.sink                            req,
   bog_if.source                          rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bog_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   localparam int NS = 5;
   bog_pkg::cfg_type cfg;

   bog_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   // A stage advances when the next one is empty or moving.
   always_comb begin
      adv[NS-1] = ~vld_ff[NS-1] | rsp.ready;
      for (int i = NS - 2; i >= 0; i--) adv[i] = ~vld_ff[i] | adv[i+1];
   end
   assign req.ready = adv[0];
   assign rsp.valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req.valid;
         for (int i = 1; i < NS; i++) if (adv[i]) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Stage 1: clamp, base coordinate, floor.
   logic [11:0] orow, ocol;
   logic [3:0]  trow, tcol;
   always_comb begin
      orow = (32'(req.data.out_row) >= 32'(COORD_LIMIT)) ? 12'(COORD_LIMIT - 1)
             : req.data.out_row;
      ocol = (32'(req.data.out_col) >= 32'(COORD_LIMIT)) ? 12'(COORD_LIMIT - 1)
             : req.data.out_col;
      trow = (32'(req.data.tap_row) >= 32'(TAP_LIMIT)) ? 4'(TAP_LIMIT - 1)
             : req.data.tap_row;
      tcol = (32'(req.data.tap_col) >= 32'(TAP_LIMIT)) ? 4'(TAP_LIMIT - 1)
             : req.data.tap_col;
   end

   logic signed [18:0] flr_ff, flc_ff;
   logic [7:0]         cwr1_ff, cwc1_ff;
   logic [15:0]        mod1_ff;
   logic signed [15:0] g1_ff, tl1_ff, bl1_ff, tr1_ff, br1_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         flr_ff <= signed'({7'd0, orow} * {15'd0, cfg.stride_rows})
                   + signed'({15'd0, trow} * {15'd0, cfg.dilation_rows})
                   - signed'({11'd0, cfg.pad_top})
                   + 19'(signed'(req.data.shift_row[15:8]));
         flc_ff <= signed'({7'd0, ocol} * {15'd0, cfg.stride_cols})
                   + signed'({15'd0, tcol} * {15'd0, cfg.dilation_cols})
                   - signed'({11'd0, cfg.pad_cols})
                   + 19'(signed'(req.data.shift_col[15:8]));
         cwr1_ff <= req.data.shift_row[7:0];
         cwc1_ff <= req.data.shift_col[7:0];
         mod1_ff <= req.data.modulation;
         g1_ff   <= req.data.upstream_grad;
         tl1_ff  <= req.data.value_top_left;
         bl1_ff  <= req.data.value_bottom_left;
         tr1_ff  <= req.data.value_top_right;
         br1_ff  <= req.data.value_bottom_right;
      end
   end

   // Stage 2: bounds, masked samples, corner weights, scaled gradient.
   logic fr_ok, cr_ok, fc_ok, cc_ok;
   logic [3:0] ok;
   logic [8:0] fwr, fwc;
   always_comb begin
      fr_ok = (flr_ff >= 0) && (flr_ff < 19'(signed'({1'b0, cfg.image_height})));
      cr_ok = (flr_ff >= -1) && (flr_ff + 1 < 19'(signed'({1'b0, cfg.image_height})));
      fc_ok = (flc_ff >= 0) && (flc_ff < 19'(signed'({1'b0, cfg.image_width})));
      cc_ok = (flc_ff >= -1) && (flc_ff + 1 < 19'(signed'({1'b0, cfg.image_width})));
      ok = {cr_ok & cc_ok, fr_ok & cc_ok, cr_ok & fc_ok, fr_ok & fc_ok};
      fwr = 9'd256 - {1'b0, cwr1_ff};
      fwc = 9'd256 - {1'b0, cwc1_ff};
   end

   logic [16:0]        crow2_ff, ccol2_ff;
   logic [3:0]         ok2_ff;
   logic [8:0]         fwr2_ff, fwc2_ff, cwr2_ff, cwc2_ff;
   logic [16:0]        wtl2_ff, wbl2_ff, wtr2_ff, wbr2_ff;
   logic signed [32:0] gs2_ff;
   logic signed [15:0] g2_ff, tl2_ff, bl2_ff, tr2_ff, br2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         crow2_ff <= flr_ff[16:0];
         ccol2_ff <= flc_ff[16:0];
         ok2_ff   <= ok;
         fwr2_ff  <= fwr;
         fwc2_ff  <= fwc;
         cwr2_ff  <= {1'b0, cwr1_ff};
         cwc2_ff  <= {1'b0, cwc1_ff};
         wtl2_ff  <= {8'd0, fwr} * {8'd0, fwc};
         wbl2_ff  <= {9'd0, cwr1_ff} * {8'd0, fwc};
         wtr2_ff  <= {8'd0, fwr} * {9'd0, cwc1_ff};
         wbr2_ff  <= {9'd0, cwr1_ff} * {9'd0, cwc1_ff};
         gs2_ff   <= 33'(g1_ff) * signed'({17'd0, mod1_ff});
         g2_ff    <= g1_ff;
         tl2_ff   <= ok[0] ? tl1_ff : 16'sd0;
         bl2_ff   <= ok[1] ? bl1_ff : 16'sd0;
         tr2_ff   <= ok[2] ? tr1_ff : 16'sd0;
         br2_ff   <= ok[3] ? br1_ff : 16'sd0;
      end
   end

   // Stage 3: first products of the derivative terms.
   logic [16:0]        crow3_ff, ccol3_ff;
   logic [3:0]         ok3_ff;
   logic [16:0]        wtl3_ff, wbl3_ff, wtr3_ff, wbr3_ff;
   logic signed [32:0] gs3_ff;
   logic signed [15:0] g3_ff;
   logic signed [26:0] drow3_ff, dcol3_ff;
   logic signed [34:0] dmod3_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         crow3_ff <= crow2_ff;
         ccol3_ff <= ccol2_ff;
         ok3_ff   <= ok2_ff;
         wtl3_ff  <= wtl2_ff;
         wbl3_ff  <= wbl2_ff;
         wtr3_ff  <= wtr2_ff;
         wbr3_ff  <= wbr2_ff;
         gs3_ff   <= gs2_ff;
         g3_ff    <= g2_ff;
         drow3_ff <= (27'(bl2_ff) - 27'(tl2_ff)) * signed'({18'd0, fwc2_ff})
                     + (27'(br2_ff) - 27'(tr2_ff)) * signed'({18'd0, cwc2_ff});
         dcol3_ff <= (27'(tr2_ff) - 27'(tl2_ff)) * signed'({18'd0, fwr2_ff})
                     + (27'(br2_ff) - 27'(bl2_ff)) * signed'({18'd0, cwr2_ff});
         dmod3_ff <= 35'(tl2_ff) * signed'({18'd0, wtl2_ff})
                     + 35'(bl2_ff) * signed'({18'd0, wbl2_ff})
                     + 35'(tr2_ff) * signed'({18'd0, wtr2_ff})
                     + 35'(br2_ff) * signed'({18'd0, wbr2_ff});
      end
   end

   // Stage 4: products with the scaled upstream gradient.
   logic [16:0]        crow4_ff, ccol4_ff;
   logic [3:0]         ok4_ff;
   logic signed [50:0] ptl4_ff, pbl4_ff, ptr4_ff, pbr4_ff;
   logic signed [59:0] prow4_ff, pcol4_ff;
   logic signed [50:0] pmod4_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         crow4_ff <= crow3_ff;
         ccol4_ff <= ccol3_ff;
         ok4_ff   <= ok3_ff;
         ptl4_ff  <= 51'(gs3_ff) * signed'({34'd0, wtl3_ff});
         pbl4_ff  <= 51'(gs3_ff) * signed'({34'd0, wbl3_ff});
         ptr4_ff  <= 51'(gs3_ff) * signed'({34'd0, wtr3_ff});
         pbr4_ff  <= 51'(gs3_ff) * signed'({34'd0, wbr3_ff});
         prow4_ff <= 60'(drow3_ff) * 60'(gs3_ff);
         pcol4_ff <= 60'(dcol3_ff) * 60'(gs3_ff);
         pmod4_ff <= 51'(dmod3_ff) * 51'(g3_ff);
      end
   end

   // Stage 5: rounding, saturation and invalid-corner zeroing.
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rsp.data.corner_row <= crow4_ff;
         rsp.data.corner_col <= ccol4_ff;
         rsp.data.valid_corners <= ok4_ff;
         rsp.data.grad_top_left <= ok4_ff[0] ? bog_pkg::round_sat(64'(ptl4_ff), 19) : '0;
         rsp.data.grad_bottom_left <= ok4_ff[1] ? bog_pkg::round_sat(64'(pbl4_ff), 19) : '0;
         rsp.data.grad_top_right <= ok4_ff[2] ? bog_pkg::round_sat(64'(ptr4_ff), 19) : '0;
         rsp.data.grad_bottom_right <= ok4_ff[3] ? bog_pkg::round_sat(64'(pbr4_ff), 19) : '0;
         rsp.data.grad_shift_row <= bog_pkg::round_sat(64'(prow4_ff), 23);
         rsp.data.grad_shift_col <= bog_pkg::round_sat(64'(pcol4_ff), 23);
         rsp.data.grad_modulation <= bog_pkg::round_sat(64'(pmod4_ff), 16);
      end
   end

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result word changed under stall");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      vld_ff == '0 |-> req.ready)
      else $error("empty pipeline refused a word");
   a_mask_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.valid_corners[0] |-> rsp.data.grad_top_left == '0)
      else $error("invalid corner has nonzero gradient");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && adv[4] |=> vld_ff[4])
      else $error("word lost between last stages");
endmodule

// File: rtl/bog_csr.sv
// APB-style configuration registers.
module bog_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bog_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output bog_pkg::cfg_type                cfg
);
   bog_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (bog_pkg::reg_index_type'(idx))
            bog_pkg::REG_PAD_TOP:       cfg_in.pad_top = csr_pwdata[7:0];
            bog_pkg::REG_PAD_COLS:      cfg_in.pad_cols = csr_pwdata[7:0];
            bog_pkg::REG_STRIDE_ROWS:   cfg_in.stride_rows = csr_pwdata[3:0];
            bog_pkg::REG_STRIDE_COLS:   cfg_in.stride_cols = csr_pwdata[3:0];
            bog_pkg::REG_DILATION_ROWS: cfg_in.dilation_rows = csr_pwdata[3:0];
            bog_pkg::REG_DILATION_COLS: cfg_in.dilation_cols = csr_pwdata[3:0];
            bog_pkg::REG_IMAGE_HEIGHT:  cfg_in.image_height = csr_pwdata[12:0];
            bog_pkg::REG_IMAGE_WIDTH:   cfg_in.image_width = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{8'd0, 8'd0, 4'd1, 4'd1, 4'd1, 4'd1, 13'd4096, 13'd4096};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (bog_pkg::reg_index_type'(idx))
         bog_pkg::REG_PAD_TOP:       csr_prdata = {24'd0, cfg_ff.pad_top};
         bog_pkg::REG_PAD_COLS:      csr_prdata = {24'd0, cfg_ff.pad_cols};
         bog_pkg::REG_STRIDE_ROWS:   csr_prdata = {28'd0, cfg_ff.stride_rows};
         bog_pkg::REG_STRIDE_COLS:   csr_prdata = {28'd0, cfg_ff.stride_cols};
         bog_pkg::REG_DILATION_ROWS: csr_prdata = {28'd0, cfg_ff.dilation_rows};
         bog_pkg::REG_DILATION_COLS: csr_prdata = {28'd0, cfg_ff.dilation_cols};
         bog_pkg::REG_IMAGE_HEIGHT:  csr_prdata = {19'd0, cfg_ff.image_height};
         bog_pkg::REG_IMAGE_WIDTH:   csr_prdata = {19'd0, cfg_ff.image_width};
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

// File: tb/tb.sv
// Self-checking testbench for the deformable convolution offset gradient pipeline.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;

   // Holds the register copy, predicts each accepted point and checks results in order.
   class grad_book;
      bog_pkg::cfg_type cfg;
      bog_pkg::rsp_word_type pending[$];
      int errors;
      int checked;

      function void clear_cfg();
         cfg = '0;
         cfg.stride_rows = 4'd1; cfg.stride_cols = 4'd1;
         cfg.dilation_rows = 4'd1; cfg.dilation_cols = 4'd1;
         cfg.image_height = 13'd4096; cfg.image_width = 13'd4096;
      endfunction

      function longint round_q824(longint x, int s);
         longint r;
         r = (x + (64'sd1 <<< (s - 1))) >>> s;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r;
      endfunction

      function void note_point(bog_pkg::req_word_type p);
         bog_pkg::rsp_word_type e;
         longint sr, sc, md, g, vtl, vbl, vtr, vbr, br, bc, flr, flc;
         longint cwr, fwr, cwc, fwc, wtl, wbl, wtr, wbr, gs, drow, dcol, dmod;
         bit frok, crok, fcok, ccok, tl, bl, tr, bre;
         sr = $signed(p.shift_row); sc = $signed(p.shift_col);
         md = p.modulation; g = $signed(p.upstream_grad);
         vtl = $signed(p.value_top_left); vbl = $signed(p.value_bottom_left);
         vtr = $signed(p.value_top_right); vbr = $signed(p.value_bottom_right);
         br = longint'(p.out_row) * cfg.stride_rows + longint'(p.tap_row) * cfg.dilation_rows
              - longint'(cfg.pad_top);
         bc = longint'(p.out_col) * cfg.stride_cols + longint'(p.tap_col) * cfg.dilation_cols
              - longint'(cfg.pad_cols);
         flr = br + (sr >>> 8);
         flc = bc + (sc >>> 8);
         cwr = sr & 255; fwr = 256 - cwr;
         cwc = sc & 255; fwc = 256 - cwc;
         frok = flr >= 0 && flr < longint'(cfg.image_height);
         crok = flr + 1 >= 0 && flr + 1 < longint'(cfg.image_height);
         fcok = flc >= 0 && flc < longint'(cfg.image_width);
         ccok = flc + 1 >= 0 && flc + 1 < longint'(cfg.image_width);
         tl = frok && fcok; bl = crok && fcok; tr = frok && ccok; bre = crok && ccok;
         // An out-of-image corner reads as a zero sample.
         if (!tl) vtl = 0;
         if (!bl) vbl = 0;
         if (!tr) vtr = 0;
         if (!bre) vbr = 0;
         wtl = fwr * fwc; wbl = cwr * fwc; wtr = fwr * cwc; wbr = cwr * cwc;
         gs = g * md;
         drow = (vbl - vtl) * fwc + (vbr - vtr) * cwc;
         dcol = (vtr - vtl) * fwr + (vbr - vbl) * cwr;
         dmod = vtl * wtl + vbl * wbl + vtr * wtr + vbr * wbr;
         e.corner_row = flr[16:0];
         e.corner_col = flc[16:0];
         e.valid_corners = {bre, tr, bl, tl};
         e.grad_top_left = tl ? 32'(round_q824(gs * wtl, 19)) : 32'd0;
         e.grad_bottom_left = bl ? 32'(round_q824(gs * wbl, 19)) : 32'd0;
         e.grad_top_right = tr ? 32'(round_q824(gs * wtr, 19)) : 32'd0;
         e.grad_bottom_right = bre ? 32'(round_q824(gs * wbr, 19)) : 32'd0;
         e.grad_shift_row = 32'(round_q824(drow * gs, 23));
         e.grad_shift_col = 32'(round_q824(dcol * gs, 23));
         e.grad_modulation = 32'(round_q824(dmod * g, 16));
         pending.push_back(e);
      endfunction

      function void check_word(bog_pkg::rsp_word_type a);
         bog_pkg::rsp_word_type e;
         logic [31:0] ev[10], av[10];
         string names[10];
         names = '{"corner_row", "corner_col", "valid_corners", "grad_top_left",
                   "grad_bottom_left", "grad_top_right", "grad_bottom_right",
                   "grad_shift_row", "grad_shift_col", "grad_modulation"};
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         ev = '{32'(e.corner_row), 32'(e.corner_col), 32'(e.valid_corners), e.grad_top_left,
                e.grad_bottom_left, e.grad_top_right, e.grad_bottom_right,
                e.grad_shift_row, e.grad_shift_col, e.grad_modulation};
         av = '{32'(a.corner_row), 32'(a.corner_col), 32'(a.valid_corners), a.grad_top_left,
                a.grad_bottom_left, a.grad_top_right, a.grad_bottom_right,
                a.grad_shift_row, a.grad_shift_col, a.grad_modulation};
         foreach (ev[i]) begin
            if (ev[i] !== av[i]) begin
               $display("%0t: %s expected %h actual %h", $time, names[i], ev[i], av[i]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [bog_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bog_if #(.payload_type(bog_pkg::req_word_type)) req_ch (clock);
   bog_if #(.payload_type(bog_pkg::rsp_word_type)) rsp_ch (clock);

   bilinear_offset_gradient dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   grad_book book = new();
   int stall_count = 0;
   int configs_used = 0;
   bit no_gaps = 0;

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: ready toggles at falling edges, words are checked at rising edges.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         rsp_ch.ready = 1;
         @(negedge clock);
         while ($urandom_range(0, 3) == 0) @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ch.ready = 0;
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) book.check_word(rsp_ch.data);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count > STALL_LIMIT) begin
         $display("%0t: watchdog expired with %0d words outstanding", $time,
                  book.pending.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_point(bog_pkg::req_word_type p);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_ch.valid = 0;
         repeat (n) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.data = p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book.note_point(p);
      @(negedge clock);
   endtask

   task automatic write_reg(bog_pkg::reg_index_type idx, logic [31:0] val);
      csr_psel = 1; csr_pwrite = 1; csr_penable = 0;
      csr_paddr = bog_pkg::CSR_ADDR_W'(idx) << 2;
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic drain();
      req_ch.valid = 0;
      while (book.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic apply_cfg(bog_pkg::cfg_type c);
      write_reg(bog_pkg::REG_PAD_TOP, 32'(c.pad_top));
      write_reg(bog_pkg::REG_PAD_COLS, 32'(c.pad_cols));
      write_reg(bog_pkg::REG_STRIDE_ROWS, 32'(c.stride_rows));
      write_reg(bog_pkg::REG_STRIDE_COLS, 32'(c.stride_cols));
      write_reg(bog_pkg::REG_DILATION_ROWS, 32'(c.dilation_rows));
      write_reg(bog_pkg::REG_DILATION_COLS, 32'(c.dilation_cols));
      write_reg(bog_pkg::REG_IMAGE_HEIGHT, 32'(c.image_height));
      write_reg(bog_pkg::REG_IMAGE_WIDTH, 32'(c.image_width));
      book.cfg = c;
      configs_used++;
   endtask

   function bog_pkg::req_word_type random_point();
      bog_pkg::req_word_type p;
      p = {$urandom, $urandom, $urandom, $urandom, $urandom};
      // Most points land near the image so corners straddle its edges.
      if ($urandom_range(0, 9) < 6) begin
         p.out_row = 12'($urandom_range(0, 40));
         p.out_col = 12'($urandom_range(0, 40));
         p.shift_row = 16'($urandom_range(0, 2047)) - 16'd1024;
         p.shift_col = 16'($urandom_range(0, 2047)) - 16'd1024;
         if ($urandom_range(0, 1)) p.modulation = 16'($urandom_range(0, 32768));
      end
      return p;
   endfunction

   function bog_pkg::cfg_type random_cfg();
      bog_pkg::cfg_type c;
      c.pad_top = 8'($urandom_range(0, 255));
      c.pad_cols = 8'($urandom_range(0, 255));
      c.stride_rows = 4'($urandom); c.stride_cols = 4'($urandom);
      c.dilation_rows = 4'($urandom); c.dilation_cols = 4'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         c.image_height = 13'($urandom); c.image_width = 13'($urandom);
      end else begin
         c.image_height = 13'($urandom_range(0, 80));
         c.image_width = 13'($urandom_range(0, 80));
      end
      return c;
   endfunction

   initial begin
      bog_pkg::req_word_type p;
      bog_pkg::cfg_type c;
      book.clear_cfg();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed points under the reset settings: field extremes and edge corners.
      p = '0;
      send_point(p);
      p = '1;
      send_point(p);
      p = '0; p.upstream_grad = 16'h7FFF; p.modulation = 16'hFFFF;
      p.value_top_left = 16'h7FFF; p.value_bottom_left = 16'h8000;
      p.value_top_right = 16'h8000; p.value_bottom_right = 16'h7FFF;
      p.shift_row = 16'h0080; p.shift_col = 16'h0080;
      p.out_row = 5; p.out_col = 5;
      send_point(p);
      p.upstream_grad = 16'h8000; p.modulation = 16'h8000;
      send_point(p);
      p.modulation = 0;
      send_point(p);
      p.modulation = 16'h8000; p.shift_row = 16'h8000; p.shift_col = 16'h7FFF;
      send_point(p);
      p.shift_row = 16'hFFFF; p.shift_col = 16'hFF00; p.out_row = 0; p.out_col = 0;
      send_point(p);
      p.out_row = 4095; p.out_col = 4095; p.tap_row = 15; p.tap_col = 15;
      p.shift_row = 16'h0000; p.shift_col = 16'h00FF;
      send_point(p);
      p.out_row = 4095; p.out_col = 4094; p.tap_row = 0; p.tap_col = 0;
      send_point(p);
      drain();

      // Extreme settings: largest pads, strides and dilations, then empty and single-pixel images.
      c = '{pad_top: 255, pad_cols: 255, stride_rows: 15, stride_cols: 15,
            dilation_rows: 15, dilation_cols: 15, image_height: 8191, image_width: 8191};
      apply_cfg(c);
      p = '1;
      send_point(p);
      p.shift_row = 16'h8000; p.out_row = 0; p.tap_row = 0;
      send_point(p);
      p = '0; p.out_row = 17; p.out_col = 17; p.upstream_grad = 16'h1000;
      p.modulation = 16'h8000; p.value_top_left = 16'h1000;
      send_point(p);
      drain();
      c = '{pad_top: 0, pad_cols: 0, stride_rows: 0, stride_cols: 0,
            dilation_rows: 0, dilation_cols: 0, image_height: 0, image_width: 0};
      apply_cfg(c);
      p.shift_row = 16'h0040;
      send_point(p);
      drain();
      c = '{pad_top: 0, pad_cols: 0, stride_rows: 1, stride_cols: 1,
            dilation_rows: 1, dilation_cols: 1, image_height: 1, image_width: 1};
      apply_cfg(c);
      p = '0; p.upstream_grad = 16'h7FFF; p.modulation = 16'hFFFF;
      p.value_top_left = 16'h8000; p.shift_row = 16'h0080; p.shift_col = 16'hFF80;
      send_point(p);
      p.shift_row = 16'hFF80; p.shift_col = 16'h0080;
      send_point(p);
      drain();

      // Random phases, each under its own setting; one phase runs without gaps.
      for (int ph = 0; ph < 8; ph++) begin
         apply_cfg(random_cfg());
         no_gaps = (ph == 3);
         for (int i = 0; i < 63; i++) send_point(random_point());
         drain();
      end
      no_gaps = 0;

      $display("tb: %0d result words checked across %0d register settings",
               book.checked, configs_used);
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", book.errors);
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
